// File: rtl/nmea_sentence_frame_checker_top_macros.svh
// Assertion helpers for the frame checker RTL.
`ifndef NMEA_SENTENCE_FRAME_CHECKER_TOP_MACROS_SVH
`define NMEA_SENTENCE_FRAME_CHECKER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NSFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define NSFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/nsfc_pkg.sv
`default_nettype none

package nsfc_pkg;

    localparam int BYTE_W              = 8;
    localparam int LEN_W               = 11;
    localparam int OUT_TDATA_W         = 16;
    localparam int DEF_MAX_FRAME_BYTES = 1024;
    localparam int RECENT_DEPTH        = 4;
    // first position at which the byte four places back may be examined
    localparam int FIRST_EXAMINE_POS   = 5;

    localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CHAR_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] PRINT_LO    = 8'h20;
    localparam logic [BYTE_W-1:0] PRINT_HI    = 8'h7E;
    localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] LETTER_BIAS = 8'd10;

    typedef enum logic [1:0] {
        PH_SEARCHING = 2'd0,
        PH_FOUND     = 2'd1,
        PH_STOPPED   = 2'd2
    } t_phase;

    // Check one character against a nibble as a hex digit, either letter case.
    function automatic logic hex_digit_matches(input logic [BYTE_W-1:0] ch,
                                               input logic [3:0]        nib);
        logic [BYTE_W-1:0] nib_ext;
        logic              hit;
        nib_ext = {4'h0, nib};
        if (nib < 4'd10) begin
            hit = (ch == CHAR_ZERO + nib_ext);
        end else begin
            hit = (ch == CHAR_UPPER_A + nib_ext - LETTER_BIAS) ||
                  (ch == CHAR_LOWER_A + nib_ext - LETTER_BIAS);
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

// File: rtl/nmea_sentence_frame_checker_top.sv
// Channel   Dir  tdata (low bit up)            tuser          tlast
// s_axis    in   data_byte[7:0]                -              last_byte
// m_axis    out  frame_length[10:0], 5'b0      frame_valid    -
//
// Throughput: one byte per cycle, sustained while the result register can take each
// last byte. A last byte is judged out of the input register and m_axis_tvalid rises at the next edge.
// Reset: i_rst_n synchronous, active low; clears the search state at once.
// Stalls: non-last bytes keep flowing while a result waits; a last byte is
// held in the input register until the result register frees up.
`default_nettype none
`include "nmea_sentence_frame_checker_top_macros.svh"

module nmea_sentence_frame_checker_top #(
    parameter int MAX_FRAME_BYTES = nsfc_pkg::DEF_MAX_FRAME_BYTES
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // slave stream
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [nsfc_pkg::BYTE_W-1:0]      s_axis_tdata,   // data_byte[7:0]
    input  wire logic                             s_axis_tlast,   // last_byte
    // master stream
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [nsfc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,   // frame_length[10:0], pad
    output logic                                  m_axis_tuser    // frame_valid
);
    import nsfc_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 2);
    localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_FIRST = POS_W'(FIRST_EXAMINE_POS);

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_data;
    logic              r_in_last;

    // search state
    logic [BYTE_W-1:0] r_recent [RECENT_DEPTH];
    logic [POS_W-1:0]  r_pos;
    logic [BYTE_W-1:0] r_xor;
    t_phase            r_phase;
    logic [LEN_W-1:0]  r_frame_end;

    // result register
    logic              r_out_valid;
    logic              r_out_frame_valid;
    logic [LEN_W-1:0]  r_out_length;

    logic              consume;
    t_phase            n_phase;
    logic [BYTE_W-1:0] n_xor;
    logic [LEN_W-1:0]  n_frame_end;
    logic [POS_W-1:0]  n_pos;
    logic              examine;
    logic              start_bad;
    logic              oldest_bad;
    logic              frame_hit;
    logic [POS_W:0]    pos_plus;
    logic              res_valid;

    // Move the held byte into the search; a last byte only when the result slot is free or being taken
    assign consume       = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || consume;

    // Classify the current byte, the window position and the oldest byte of the window
    always_comb begin
        pos_plus   = {1'b0, r_pos} + {{POS_W{1'b0}}, 1'b1};
        start_bad  = (r_pos == '0) && (r_in_data != CHAR_DOLLAR);
        examine    = (r_pos >= POS_FIRST) && (r_pos <= POS_MAX);
        oldest_bad = (r_recent[0] < PRINT_LO) || (r_recent[0] > PRINT_HI);
        frame_hit  = (r_recent[0] == CHAR_STAR) && (r_recent[3] == CHAR_CR) &&
                     (r_in_data == CHAR_LF) &&
                     hex_digit_matches(r_recent[1], r_xor[7:4]) &&
                     hex_digit_matches(r_recent[2], r_xor[3:0]);
    end

    // Next search phase
    always_comb begin
        n_phase = r_phase;
        if (start_bad) begin
            n_phase = PH_STOPPED;
        end else if (r_phase == PH_SEARCHING && examine) begin
            if (oldest_bad) begin
                n_phase = PH_STOPPED;
            end else if (frame_hit) begin
                n_phase = PH_FOUND;
            end
        end
    end

    // Datapath: running XOR, frame end, position and verdict
    always_comb begin
        n_xor       = r_xor;
        n_frame_end = r_frame_end;
        if (!start_bad && r_phase == PH_SEARCHING && examine && !oldest_bad) begin
            if (r_recent[0] != CHAR_STAR) begin
                n_xor = r_xor ^ r_recent[0];
            end else if (frame_hit) begin
                n_frame_end = LEN_W'(pos_plus);
            end
        end
        n_pos     = (r_pos <= POS_MAX) ? POS_W'(pos_plus) : r_pos;
        res_valid = (n_phase == PH_FOUND) && (n_pos <= POS_MAX);
    end

    // Input register: load on every transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // Search state: advance per byte, clear after a last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (consume && r_in_last)) begin
            for (int i = 0; i < RECENT_DEPTH; i++) begin
                r_recent[i] <= '0;
            end
            r_pos       <= '0;
            r_xor       <= '0;
            r_phase     <= PH_SEARCHING;
            r_frame_end <= '0;
        end else if (consume) begin
            for (int i = 0; i < RECENT_DEPTH - 1; i++) begin
                r_recent[i] <= r_recent[i+1];
            end
            r_recent[RECENT_DEPTH-1] <= r_in_data;
            r_pos       <= n_pos;
            r_xor       <= n_xor;
            r_phase     <= n_phase;
            r_frame_end <= n_frame_end;
        end
    end

    // Result register: fill on a last byte, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (consume && r_in_last) begin
            r_out_frame_valid <= res_valid;
            r_out_length      <= res_valid ? n_frame_end : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_frame_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-LEN_W){1'b0}}, r_out_length};

    // Checks
    `NSFC_ASSERT_NOW(a_pos_saturates, i_clk, i_rst_n, 1'b1,
        r_pos <= POS_MAX + POS_W'(1), "position ran past saturation")
    `NSFC_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, consume && r_in_last,
        r_out_valid && (r_pos == '0) && (r_phase == PH_SEARCHING),
        "last byte did not post a result and clear state")
    `NSFC_ASSERT_NOW(a_invalid_zero_len, i_clk, i_rst_n, r_out_valid && !r_out_frame_valid,
        r_out_length == '0, "invalid result with nonzero length")
    `NSFC_ASSERT_NOW(a_valid_min_len, i_clk, i_rst_n,
        r_out_valid && r_out_frame_valid && (MAX_FRAME_BYTES < 2048),
        r_out_length >= LEN_W'(FIRST_EXAMINE_POS + 1), "valid frame shorter than minimum")

endmodule

`default_nettype wire
